// ===== hw/rtl/nst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nst_pkg;

  localparam int unsigned OffsetBitsDef = 16;
  localparam int unsigned LookDepthDef = 4;
  localparam int unsigned PrefixLen = 7;

  typedef enum logic [5:0] {
    K_EOF, K_BAD, K_NUM, K_ID, K_LP, K_RP, K_COMMA, K_DOT, K_SEMI, K_ASSIGN,
    K_PLUS, K_MINUS, K_STAR, K_SLASH, K_PCT, K_CARET, K_EQ, K_NE, K_LT, K_LE,
    K_GT, K_GE, K_AND, K_OR, K_NOT, K_LOCAL, K_IF, K_THEN, K_ELSEIF, K_ELSE,
    K_END, K_WHILE, K_DO, K_FOR, K_RETURN
  } kind_e;

  localparam logic [4:0] M_IDLE = 5'd0, M_DASH = 5'd1, M_DASH2 = 5'd2,
    M_DASH2B = 5'd3, M_LINE = 5'd4, M_BLOCK = 5'd5, M_BLOCK_R = 5'd6,
    M_IDENT = 5'd7, M_EQ = 5'd8, M_TILDE = 5'd9, M_LT = 5'd10, M_GT = 5'd11,
    M_DOT = 5'd12, M_ZERO = 5'd13, M_INT = 5'd14, M_FRAC = 5'd15,
    M_EXP = 5'd16, M_EXPS = 5'd17, M_EXPD = 5'd18, M_HEX_X = 5'd19,
    M_HEX_XD = 5'd20, M_HEXI = 5'd21, M_HEXF = 5'd22;

  // feed outcome
  localparam logic [1:0] R_TAKE = 2'd0, R_AGAIN = 2'd1, R_RELEX = 2'd2;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic kind_e word_kind(input logic [55:0] p, input logic [2:0] len);
    kind_e k;
    k = K_ID;
    case (len)
      3'd2: begin
        if (p[15:0] == {"f", "i"}) k = K_IF;
        if (p[15:0] == {"o", "d"}) k = K_DO;
        if (p[15:0] == {"r", "o"}) k = K_OR;
      end
      3'd3: begin
        if (p[23:0] == {"d", "n", "e"}) k = K_END;
        if (p[23:0] == {"r", "o", "f"}) k = K_FOR;
        if (p[23:0] == {"d", "n", "a"}) k = K_AND;
        if (p[23:0] == {"t", "o", "n"}) k = K_NOT;
      end
      3'd4: begin
        if (p[31:0] == {"n", "e", "h", "t"}) k = K_THEN;
        if (p[31:0] == {"e", "s", "l", "e"}) k = K_ELSE;
      end
      3'd5: begin
        if (p[39:0] == {"l", "a", "c", "o", "l"}) k = K_LOCAL;
        if (p[39:0] == {"e", "l", "i", "h", "w"}) k = K_WHILE;
      end
      3'd6: begin
        if (p[47:0] == {"f", "i", "e", "s", "l", "e"}) k = K_ELSEIF;
        if (p[47:0] == {"n", "r", "u", "t", "e", "r"}) k = K_RETURN;
      end
      default: k = K_ID;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nst_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one feed step of the lexer on one queued symbol
module nst_core import nst_pkg::*; #(
  parameter int unsigned OffsetBits = OffsetBitsDef,
  parameter int unsigned CntBits = 3
) (
  input  wire logic [4:0]            mode_i,
  input  wire logic [7:0]            ch_i,
  input  wire logic                  is_end_i,
  input  wire logic [OffsetBits-1:0] off_i,
  input  wire logic [OffsetBits-1:0] begin_i,
  input  wire logic [CntBits-1:0]    la_cnt_i,
  input  wire logic [55:0]           prefix_i,
  output logic [4:0]                 mode_o,
  output logic [1:0]                 res_o,
  output logic                       emit_o,
  output kind_e                      kind_o,
  output logic [OffsetBits-1:0]      tstart_o,
  output logic [OffsetBits:0]        tend_o,
  output logic                       set_begin_o,
  output logic                       clr_la_o,
  output logic                       push_la_o,
  output logic                       clr_pref_o,
  output logic                       wr_pref_o
);
  logic [7:0] c;
  logic [OffsetBits-1:0] idx;
  logic [OffsetBits:0] off_x;
  logic [2:0] wlen;
  logic digit, hex;

  always_comb begin
    c = ch_i;
    digit = !is_end_i && is_digit(c);
    hex = !is_end_i && is_hex(c);
    idx = off_i - begin_i;
    off_x = {1'b0, off_i};
    wlen = (off_i < begin_i || idx > OffsetBits'(6)) ? 3'd7 : idx[2:0];
    mode_o = M_IDLE;
    res_o = R_AGAIN;
    emit_o = 1'b0;
    kind_o = K_BAD;
    tstart_o = begin_i;
    tend_o = off_x;
    set_begin_o = 1'b0;
    clr_la_o = 1'b0;
    push_la_o = 1'b0;
    clr_pref_o = 1'b0;
    wr_pref_o = 1'b0;
    case (mode_i)
      M_IDLE: begin
        res_o = R_TAKE;
        if (!is_end_i && !is_space(c)) begin
          set_begin_o = 1'b1;
          clr_la_o = 1'b1;
          if (c == "-") mode_o = M_DASH;
          else if (c == "0") mode_o = M_ZERO;
          else if (is_digit(c)) mode_o = M_INT;
          else if (c == ".") mode_o = M_DOT;
          else if (is_alpha(c) || c == "_") begin
            clr_pref_o = 1'b1;
            mode_o = M_IDENT;
          end else if (c == "=") mode_o = M_EQ;
          else if (c == "~") mode_o = M_TILDE;
          else if (c == "<") mode_o = M_LT;
          else if (c == ">") mode_o = M_GT;
          else begin
            emit_o = 1'b1;
            tstart_o = off_i;
            tend_o = off_x + (OffsetBits+1)'(1);
            case (c)
              "(": kind_o = K_LP;
              ")": kind_o = K_RP;
              ",": kind_o = K_COMMA;
              ";": kind_o = K_SEMI;
              "+": kind_o = K_PLUS;
              "*": kind_o = K_STAR;
              "/": kind_o = K_SLASH;
              "%": kind_o = K_PCT;
              "^": kind_o = K_CARET;
              default: kind_o = K_BAD;
            endcase
          end
        end
      end
      M_DASH: begin
        if (!is_end_i && c == "-") begin
          mode_o = M_DASH2; res_o = R_TAKE;
        end else begin
          emit_o = 1'b1; kind_o = K_MINUS;
        end
      end
      M_DASH2, M_DASH2B: begin
        res_o = R_TAKE;
        if (is_end_i || c == 8'h0a) mode_o = M_IDLE;
        else if (c == "[") mode_o = (mode_i == M_DASH2) ? M_DASH2B : M_BLOCK;
        else mode_o = M_LINE;
      end
      M_LINE: begin
        res_o = R_TAKE;
        mode_o = (is_end_i || c == 8'h0a) ? M_IDLE : M_LINE;
      end
      M_BLOCK, M_BLOCK_R: begin
        res_o = R_TAKE;
        if (is_end_i || (c == "]" && mode_i == M_BLOCK_R)) mode_o = M_IDLE;
        else mode_o = (c == "]") ? M_BLOCK_R : M_BLOCK;
      end
      M_IDENT: begin
        if (!is_end_i && (is_alpha(c) || digit || c == "_")) begin
          res_o = R_TAKE; mode_o = M_IDENT; wr_pref_o = 1'b1;
        end else begin
          emit_o = 1'b1;
          kind_o = (off_i < begin_i) ? K_ID : word_kind(prefix_i, wlen);
        end
      end
      M_EQ, M_TILDE, M_LT, M_GT: begin
        if (!is_end_i && c == "=") begin
          emit_o = 1'b1; res_o = R_TAKE; tend_o = off_x + (OffsetBits+1)'(1);
          case (mode_i)
            M_EQ: kind_o = K_EQ;
            M_TILDE: kind_o = K_NE;
            M_LT: kind_o = K_LE;
            default: kind_o = K_GE;
          endcase
        end else begin
          emit_o = 1'b1;
          case (mode_i)
            M_EQ: kind_o = K_ASSIGN;
            M_TILDE: kind_o = K_BAD;
            M_LT: kind_o = K_LT;
            default: kind_o = K_GT;
          endcase
        end
      end
      M_DOT: begin
        if (digit) begin
          mode_o = M_FRAC; res_o = R_TAKE;
        end else begin
          emit_o = 1'b1; kind_o = K_DOT;
        end
      end
      M_ZERO, M_INT, M_FRAC: begin
        res_o = R_TAKE;
        if (digit) mode_o = (mode_i == M_ZERO) ? M_INT : mode_i;
        else if (mode_i == M_ZERO && !is_end_i && (c == "x" || c == "X")) begin
          push_la_o = 1'b1; mode_o = M_HEX_X;
        end else if (mode_i != M_FRAC && !is_end_i && c == ".") mode_o = M_FRAC;
        else if (!is_end_i && (c == "e" || c == "E")) begin
          push_la_o = 1'b1; mode_o = M_EXP;
        end else begin
          emit_o = 1'b1; kind_o = K_NUM; res_o = R_AGAIN; mode_o = M_IDLE;
        end
      end
      M_HEXI, M_HEXF: begin
        res_o = R_TAKE;
        if (hex) mode_o = mode_i;
        else if (mode_i == M_HEXI && !is_end_i && c == ".") mode_o = M_HEXF;
        else if (!is_end_i && (c == "p" || c == "P")) begin
          push_la_o = 1'b1; mode_o = M_EXP;
        end else begin
          emit_o = 1'b1; kind_o = K_NUM; res_o = R_AGAIN; mode_o = M_IDLE;
        end
      end
      M_EXPD: begin
        if (digit) begin
          res_o = R_TAKE; mode_o = M_EXPD;
        end else begin
          emit_o = 1'b1; kind_o = K_NUM;
        end
      end
      M_EXP, M_EXPS, M_HEX_X, M_HEX_XD: begin
        res_o = R_TAKE;
        if ((mode_i == M_HEX_X || mode_i == M_HEX_XD) ? hex : digit) begin
          clr_la_o = 1'b1;
          mode_o = (mode_i == M_HEX_X) ? M_HEXI : (mode_i == M_HEX_XD) ? M_HEXF : M_EXPD;
        end else if (mode_i == M_EXP && !is_end_i && (c == "+" || c == "-")) begin
          push_la_o = 1'b1; mode_o = M_EXPS;
        end else if (mode_i == M_HEX_X && !is_end_i && c == ".") begin
          push_la_o = 1'b1; mode_o = M_HEX_XD;
        end else begin
          emit_o = 1'b1; kind_o = K_NUM; res_o = R_RELEX; mode_o = M_IDLE;
          tend_o = (off_i >= OffsetBits'(la_cnt_i)) ?
                   {1'b0, off_i - OffsetBits'(la_cnt_i)} : '0;
        end
      end
      default: begin
        mode_o = M_IDLE; res_o = R_AGAIN;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/numeric_script_tokenizer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// streaming lexer: source bytes come in on the s_axis request channel, tokens
// leave on m_axis, zero to six tokens per request.
// s_axis_tdata: byte_value[7:0]; s_axis_tuser: byte_present[0], end_of_source[1].
// m_axis_tdata: token_kind[5:0], token_start[21:6], token_length[37:22],
// offset_overflow[38], zero pad to 40 bits; m_axis_tlast marks the last token
// that a request caused.
// one shared feed step (nst_core) runs once per cycle, unless a token it makes
// must wait for the output register, over a small symbol queue holding the byte,
// the end mark and any re-lexed lookahead bytes. a symbol that ends a token is
// fed a second time; a failed exponent or hex prefix feeds its buffered suffix bytes (at most 2) again.
// s_axis_tready is low after acceptance until every feed step is done and,
// with end_of_source, the EOF token is loaded; longer while the receiver stalls.
// a token sits in the output register until the next token or the end of the
// request is known, then is offered; a step that makes a token waits while
// the previous one is not taken, so a stalled receiver stalls the source.
// after reset (rst_ni low, async) the lexer is between tokens at offset 0;
// end_of_source yields an EOF token and returns the lexer to that state.
module numeric_script_tokenizer_unit import nst_pkg::*; #(
  parameter int unsigned OffsetBits = OffsetBitsDef,
  parameter int unsigned LookDepth = LookDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // byte_value
  input  wire logic [1:0]  s_axis_tuser,   // byte_present, end_of_source
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // kind, start, length, overflow
  output logic             m_axis_tlast
);
  localparam int unsigned CntBits = $clog2(LookDepth + 1);
  localparam int unsigned QDepth = LookDepth + 2;
  localparam int unsigned QBits = $clog2(QDepth + 1);
  localparam logic [OffsetBits-1:0] OffMax = '1;

  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_EOF = 2'd2, S_DONE = 2'd3;

  logic [1:0] st_q, st_d;
  logic [4:0] mode_q;
  logic [7:0] la_q [LookDepth];
  logic [CntBits-1:0] la_cnt_q;
  logic [OffsetBits-1:0] cur_q, beg_q;
  logic [7:0] pref_q [PrefixLen];
  logic ovf_q, eos_q;
  logic [7:0] qch_q [QDepth];
  logic qend_q [QDepth];
  logic [OffsetBits-1:0] qoff_q [QDepth];
  logic [QBits-1:0] qn_q;
  logic ov_q, ov_d;
  logic [5:0] ok_q;
  logic [15:0] os_q, olen_q;
  logic oovf_q;

  logic [4:0] c_mode;
  logic [1:0] c_res;
  logic c_emit, c_setb, c_clrla, c_push, c_clrp, c_wrp;
  kind_e c_kind;
  logic [OffsetBits-1:0] c_ts, idx;
  logic [OffsetBits:0] c_te;
  logic [55:0] pref_flat;
  logic out_free, out_take, busy, step, load_eof;

  always_comb begin
    for (int i = 0; i < PrefixLen; i++) pref_flat[8*i +: 8] = pref_q[i];
  end

  nst_core #(.OffsetBits(OffsetBits), .CntBits(CntBits)) u_core (
    .mode_i(mode_q), .ch_i(qch_q[0]), .is_end_i(qend_q[0]), .off_i(qoff_q[0]),
    .begin_i(beg_q), .la_cnt_i(la_cnt_q), .prefix_i(pref_flat),
    .mode_o(c_mode), .res_o(c_res), .emit_o(c_emit), .kind_o(c_kind),
    .tstart_o(c_ts), .tend_o(c_te), .set_begin_o(c_setb), .clr_la_o(c_clrla),
    .push_la_o(c_push), .clr_pref_o(c_clrp), .wr_pref_o(c_wrp)
  );

  assign idx = qoff_q[0] - beg_q;
  assign busy = (st_q == S_RUN) && (qn_q != '0);
  // a held token is offered once a following token or the request end is known
  assign m_axis_tvalid = ov_q && ((st_q != S_RUN) || (busy && c_emit));
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign out_free = !ov_q || out_take;
  assign step = busy && (out_free || !c_emit);
  assign load_eof = (st_q == S_EOF) && out_free;
  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tlast = (st_q == S_DONE);
  assign m_axis_tdata = {1'b0, oovf_q, olen_q, os_q, ok_q};

  function automatic logic [15:0] sat16(input logic [OffsetBits:0] v);
    if ((v >> 16) != '0) return 16'hffff;
    return 16'(v);
  endfunction

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (s_axis_tvalid) st_d = S_RUN;
      S_RUN: if (qn_q == '0) st_d = eos_q ? S_EOF : S_DONE;
      S_EOF: if (out_free) st_d = S_DONE;
      S_DONE: if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q && !out_take;
    if ((step && c_emit) || load_eof) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      mode_q <= M_IDLE;
      la_cnt_q <= '0;
      cur_q <= '0;
      beg_q <= '0;
      ovf_q <= 1'b0;
      eos_q <= 1'b0;
      qn_q <= '0;
      ov_q <= 1'b0;
      for (int i = 0; i < LookDepth; i++) la_q[i] <= '0;
      for (int i = 0; i < PrefixLen; i++) pref_q[i] <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      case (st_q)
        S_IDLE: if (s_axis_tvalid) begin
          eos_q <= s_axis_tuser[1];
          qn_q <= QBits'(s_axis_tuser[0]) + QBits'(s_axis_tuser[1]);
          qch_q[0] <= s_axis_tdata;
          qend_q[0] <= !s_axis_tuser[0];
          qoff_q[0] <= cur_q;
          qend_q[1] <= 1'b1;
          if (s_axis_tuser[0]) begin
            if (cur_q == OffMax) ovf_q <= 1'b1;
            qoff_q[1] <= (cur_q == OffMax) ? cur_q : cur_q + OffsetBits'(1);
            if (cur_q != OffMax) cur_q <= cur_q + OffsetBits'(1);
          end
        end
        S_RUN: if (step) begin
          mode_q <= c_mode;
          if (c_setb) beg_q <= qoff_q[0];
          if (c_clrla) la_cnt_q <= '0;
          if (c_push && la_cnt_q < CntBits'(LookDepth)) begin
            la_q[la_cnt_q[$clog2(LookDepth)-1:0]] <= qch_q[0];
            la_cnt_q <= la_cnt_q + CntBits'(1);
          end
          if (c_clrp) begin
            for (int i = 1; i < PrefixLen; i++) pref_q[i] <= '0;
            pref_q[0] <= qch_q[0];
          end
          if (c_wrp && qoff_q[0] >= beg_q && idx < OffsetBits'(PrefixLen))
            pref_q[idx[2:0]] <= qch_q[0];
          if (c_emit) begin
            ok_q <= c_kind;
            os_q <= sat16({1'b0, c_ts});
            olen_q <= (c_te > {1'b0, c_ts}) ? sat16(c_te - {1'b0, c_ts}) : 16'd0;
            oovf_q <= ovf_q;
          end
          if (c_res == R_TAKE) begin
            for (int i = 0; i < QDepth - 1; i++) begin
              qch_q[i] <= qch_q[i+1];
              qend_q[i] <= qend_q[i+1];
              qoff_q[i] <= qoff_q[i+1];
            end
            qn_q <= qn_q - QBits'(1);
          end else if (c_res == R_RELEX) begin
            // lookahead bytes go back in front of the current symbol
            for (int j = 0; j < QDepth; j++) begin
              if (j < int'(la_cnt_q)) begin
                qch_q[j] <= la_q[j];
                qend_q[j] <= 1'b0;
                qoff_q[j] <= qoff_q[0] - OffsetBits'(la_cnt_q) + OffsetBits'(j);
              end else if (j - int'(la_cnt_q) < 2) begin
                qch_q[j] <= qch_q[j - int'(la_cnt_q)];
                qend_q[j] <= qend_q[j - int'(la_cnt_q)];
                qoff_q[j] <= qoff_q[j - int'(la_cnt_q)];
              end
            end
            qn_q <= qn_q + QBits'(la_cnt_q);
            la_cnt_q <= '0;
          end
        end
        S_EOF: if (out_free) begin
          ok_q <= K_EOF;
          os_q <= sat16({1'b0, cur_q});
          olen_q <= '0;
          oovf_q <= ovf_q;
          mode_q <= M_IDLE;
          la_cnt_q <= '0;
          cur_q <= '0;
          beg_q <= '0;
          ovf_q <= 1'b0;
          for (int i = 0; i < LookDepth; i++) la_q[i] <= '0;
          for (int i = 0; i < PrefixLen; i++) pref_q[i] <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !s_axis_tready) else $error("ready while busy");
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qn_q <= QBits'(QDepth)) else $error("queue overrun");
  a_la_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    la_cnt_q <= CntBits'(LookDepth)) else $error("lookahead overrun");
  a_eof_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EOF && out_free) |=> cur_q == '0 && mode_q == M_IDLE)
    else $error("eof did not reset lexer");
`endif
endmodule
`default_nettype wire

// ===== test/token_checker.sv =====
`timescale 1ns / 1ps
module token_checker import nst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  output int               fail_count_o,
  output int               pending_o,
  output int               tokens_seen_o
);

  localparam longint OffMax = 65535;
  localparam int EndMark = -1;
  localparam int MaxTokens = 6;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        ovf;
    logic        last;
  } token_t;

  token_t tokens_exp[$];

  logic [4:0] mode;
  logic [7:0] look [4];
  int         look_cnt;
  longint     cur_off;
  longint     tok_begin;
  logic [7:0] prefix [7];
  bit         ovf_seen;
  int         step_tokens;

  function automatic bit is_sp(int c);
    return c == 32 || (c >= 9 && c <= 13);
  endfunction
  function automatic bit is_dig(int c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alp(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_hx(int c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic void lexer_clear();
    mode = M_IDLE;
    foreach (look[i]) look[i] = 8'd0;
    look_cnt = 0;
    cur_off = 0;
    tok_begin = 0;
    foreach (prefix[i]) prefix[i] = 8'd0;
    ovf_seen = 0;
  endfunction

  function automatic void push_token(kind_e k, longint s, longint e);
    token_t t;
    longint l;
    if (step_tokens >= MaxTokens) return;
    l = e > s ? e - s : 0;
    t.kind = k;
    t.start = s > 65535 ? 16'hFFFF : s[15:0];
    t.len = l > 65535 ? 16'hFFFF : l[15:0];
    t.ovf = ovf_seen;
    t.last = 1'b0;
    tokens_exp.push_back(t);
    step_tokens++;
  endfunction

  function automatic kind_e keyword_of(longint len);
    string w;
    kind_e k;
    w = "";
    k = K_ID;
    if (len < 1 || len > 6) return K_ID;
    for (int i = 0; i < len; i++) w = {w, string'(prefix[i])};
    case (w)
      "local": k = K_LOCAL;   "if": k = K_IF;         "then": k = K_THEN;
      "elseif": k = K_ELSEIF; "else": k = K_ELSE;     "end": k = K_END;
      "while": k = K_WHILE;   "do": k = K_DO;         "for": k = K_FOR;
      "return": k = K_RETURN; "and": k = K_AND;       "or": k = K_OR;
      "not": k = K_NOT;
      default: k = K_ID;
    endcase
    return k;
  endfunction

  function automatic void keep_look(int c);
    if (look_cnt < 4) begin
      look[look_cnt] = c[7:0];
      look_cnt++;
    end
  endfunction

  // returns R_TAKE, R_AGAIN or R_RELEX
  function automatic logic [1:0] lex_symbol(int c, longint off);
    logic [4:0] m;
    kind_e k;
    bit hexm;
    longint n;
    m = mode;
    if (m == M_IDLE) begin
      if (c == EndMark || is_sp(c)) return R_TAKE;
      tok_begin = off;
      look_cnt = 0;
      if (c == "-") mode = M_DASH;
      else if (c == "0") mode = M_ZERO;
      else if (is_dig(c)) mode = M_INT;
      else if (c == ".") mode = M_DOT;
      else if (is_alp(c) || c == "_") begin
        foreach (prefix[i]) prefix[i] = 8'd0;
        prefix[0] = c[7:0];
        mode = M_IDENT;
      end
      else if (c == "=") mode = M_EQ;
      else if (c == "~") mode = M_TILDE;
      else if (c == "<") mode = M_LT;
      else if (c == ">") mode = M_GT;
      else begin
        case (c)
          "(": k = K_LP;    ")": k = K_RP;    ",": k = K_COMMA;
          ";": k = K_SEMI;  "+": k = K_PLUS;  "*": k = K_STAR;
          "/": k = K_SLASH; "%": k = K_PCT;   "^": k = K_CARET;
          default: k = K_BAD;
        endcase
        push_token(k, off, off + 1);
      end
      return R_TAKE;
    end
    case (m)
      M_DASH: begin
        if (c == "-") begin mode = M_DASH2; return R_TAKE; end
        push_token(K_MINUS, tok_begin, off);
      end
      M_DASH2, M_DASH2B: begin
        if (c == EndMark || c == 10) mode = M_IDLE;
        else if (c == "[") mode = (m == M_DASH2) ? M_DASH2B : M_BLOCK;
        else mode = M_LINE;
        return R_TAKE;
      end
      M_LINE: begin
        if (c == EndMark || c == 10) mode = M_IDLE;
        return R_TAKE;
      end
      M_BLOCK, M_BLOCK_R: begin
        if (c == EndMark || (c == "]" && m == M_BLOCK_R)) mode = M_IDLE;
        else mode = (c == "]") ? M_BLOCK_R : M_BLOCK;
        return R_TAKE;
      end
      M_IDENT: begin
        if (c != EndMark && (is_alp(c) || is_dig(c) || c == "_")) begin
          n = off - tok_begin;
          if (off >= tok_begin && n < 7) prefix[n] = c[7:0];
          return R_TAKE;
        end
        push_token(keyword_of(off >= tok_begin ? off - tok_begin : 0), tok_begin, off);
      end
      M_EQ, M_TILDE, M_LT, M_GT: begin
        if (c == "=") begin
          case (m)
            M_EQ: k = K_EQ; M_TILDE: k = K_NE; M_LT: k = K_LE; default: k = K_GE;
          endcase
          push_token(k, tok_begin, off + 1);
          mode = M_IDLE;
          return R_TAKE;
        end
        case (m)
          M_EQ: k = K_ASSIGN; M_TILDE: k = K_BAD; M_LT: k = K_LT; default: k = K_GT;
        endcase
        push_token(k, tok_begin, off);
      end
      M_DOT: begin
        if (is_dig(c)) begin mode = M_FRAC; return R_TAKE; end
        push_token(K_DOT, tok_begin, off);
      end
      M_ZERO, M_INT, M_FRAC: begin
        if (is_dig(c)) begin
          if (m == M_ZERO) mode = M_INT;
          return R_TAKE;
        end
        if (m == M_ZERO && (c == "x" || c == "X")) begin
          keep_look(c); mode = M_HEX_X; return R_TAKE;
        end
        if (m != M_FRAC && c == ".") begin mode = M_FRAC; return R_TAKE; end
        if (c == "e" || c == "E") begin keep_look(c); mode = M_EXP; return R_TAKE; end
        push_token(K_NUM, tok_begin, off);
      end
      M_HEXI, M_HEXF: begin
        if (is_hx(c)) return R_TAKE;
        if (m == M_HEXI && c == ".") begin mode = M_HEXF; return R_TAKE; end
        if (c == "p" || c == "P") begin keep_look(c); mode = M_EXP; return R_TAKE; end
        push_token(K_NUM, tok_begin, off);
      end
      M_EXPD: begin
        if (is_dig(c)) return R_TAKE;
        push_token(K_NUM, tok_begin, off);
      end
      M_EXP, M_EXPS, M_HEX_X, M_HEX_XD: begin
        hexm = (m == M_HEX_X || m == M_HEX_XD);
        n = look_cnt;
        if (hexm ? is_hx(c) : is_dig(c)) begin
          look_cnt = 0;
          mode = (m == M_HEX_X) ? M_HEXI : (m == M_HEX_XD) ? M_HEXF : M_EXPD;
          return R_TAKE;
        end
        if (m == M_EXP && (c == "+" || c == "-")) begin
          keep_look(c); mode = M_EXPS; return R_TAKE;
        end
        if (m == M_HEX_X && c == ".") begin keep_look(c); mode = M_HEX_XD; return R_TAKE; end
        push_token(K_NUM, tok_begin, off >= n ? off - n : 0);
        mode = M_IDLE;
        return R_RELEX;
      end
      default: ;
    endcase
    mode = M_IDLE;
    return R_AGAIN;
  endfunction

  function automatic void predict_request(logic [7:0] b, bit present, bit eos);
    int     sym [16];
    longint soff [16];
    int     tsym [16];
    longint tsoff [16];
    int     n, i, t, guard;
    longint base;
    logic [1:0] r;
    n = 0; i = 0; guard = 64;
    step_tokens = 0;
    if (present) begin
      sym[n] = b; soff[n] = cur_off; n++;
      if (cur_off >= OffMax) ovf_seen = 1;
      else cur_off++;
    end
    if (eos) begin sym[n] = EndMark; soff[n] = cur_off; n++; end
    while (i < n && guard > 0) begin
      guard--;
      r = lex_symbol(sym[i], soff[i]);
      if (r == R_TAKE) i++;
      else if (r == R_RELEX) begin
        // replay the buffered suffix bytes ahead of the failing symbol
        t = 0;
        base = soff[i] >= look_cnt ? soff[i] - look_cnt : 0;
        for (int j = 0; j < look_cnt && t < 16; j++, t++) begin
          tsym[t] = look[j]; tsoff[t] = base + j;
        end
        for (int j = i; j < n && t < 16; j++, t++) begin
          tsym[t] = sym[j]; tsoff[t] = soff[j];
        end
        for (int j = 0; j < t; j++) begin sym[j] = tsym[j]; soff[j] = tsoff[j]; end
        n = t; i = 0; look_cnt = 0;
      end
    end
    if (eos) begin
      push_token(K_EOF, cur_off, cur_off);
      lexer_clear();
    end
    if (step_tokens > 0) tokens_exp[tokens_exp.size() - 1].last = 1'b1;
  endfunction

  token_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lexer_clear();
      tokens_exp.delete();
      fail_count_o <= 0;
      tokens_seen_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_request(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tdata[5:0];
        got.start = m_axis_tdata[21:6];
        got.len = m_axis_tdata[37:22];
        got.ovf = m_axis_tdata[38];
        got.last = m_axis_tlast;
        tokens_seen_o <= tokens_seen_o + 1;
        if (tokens_exp.size() == 0) begin
          $display("%0t: unexpected token kind=%0d start=%0d len=%0d ovf=%0b last=%0b",
                   $time, got.kind, got.start, got.len, got.ovf, got.last);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = tokens_exp.pop_front();
          if (got != want) begin
            $display("%0t: token mismatch expected kind=%0d start=%0d len=%0d ovf=%0b last=%0b",
                     $time, want.kind, want.start, want.len, want.ovf, want.last);
            $display("%0t:                actual   kind=%0d start=%0d len=%0d ovf=%0b last=%0b",
                     $time, got.kind, got.start, got.len, got.ovf, got.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = tokens_exp.size();

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import nst_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count, pending, tokens_seen;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int bytes_sent = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  string snippets [] = '{
    "local", "if", "then", "elseif", "else", "end", "while", "do", "for",
    "return", "and", "or", "not", "x", "_tmp9", "elsei", "returns", "Local",
    "0", "42", "3.14", ".5", "0x1F", "0X.aP+3", "1e+", "1e-7", "2E", "0x",
    "0x.", "0x.g", "7e+q", "0xfp", "1.e5", "09.", "(", ")", ",", ".", ";",
    "=", "==", "+", "-", "*", "/", "%", "^", "~", "~=", "<", "<=", ">", ">=",
    "-- note\n", "--[[ a ] b ]]", "--[x\n", "--\n", " ", "\t", "\n", "\r", "@"
  };

  numeric_script_tokenizer_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  token_checker checker_u (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .tokens_seen_o(tokens_seen)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_request(logic [7:0] b, bit present, bit eos);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= {eos, present};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b1, 1'b0);
  endtask

  task automatic end_source();
    send_request(8'd0, 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_script(int target);
    int r;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_text(snippets[$urandom_range(snippets.size() - 1)]);
        if ($urandom_range(2) == 0) send_text(" ");
      end else if (r < 88) begin
        send_request($urandom_range(255), 1'b1, 1'b0);
      end else if (r < 92) begin
        // idle request: neither a byte nor the end of source
        send_request($urandom_range(255), 1'b0, 1'b0);
      end else if (r < 96) begin
        send_request($urandom_range(255), 1'b1, 1'b1);
      end else begin
        end_source();
      end
    end
  endtask

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: operators, keywords, failed exponents and hex prefixes
    send_text("if a~=b~c--[[x]]0x.1e+;");
    end_source();
    send_text("1e-q 0xg");
    send_request("-", 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_text("--[[ open");
    end_source();
    wait_drained();

    snk_idle_pct = 0;  src_idle_pct = 0;  random_script(150);
    end_source();
    src_idle_pct = 54; random_script(270);
    end_source();
    wait_drained();
    src_idle_pct = 0;  snk_idle_pct = 54;
    hold_req = ~hold_req;
    random_script(400);
    end_source();
    src_idle_pct = 16; snk_idle_pct = 16; random_script(500);
    end_source();

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d requests (mixed keywords, numbers, comments, noise, end marks),",
             bytes_sent);
    $display("checked %0d tokens under four stall profiles and a long output hold-off",
             tokens_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== numeric_script_tokenizer_unit.f =====
hw/rtl/nst_pkg.sv
hw/rtl/nst_core.sv
hw/rtl/numeric_script_tokenizer_unit.sv
test/token_checker.sv
test/testbench.sv
